// ===== hw/rtl/ptdc_pkg.sv =====
// shared types and constants for the push-to-talk delay controller
`default_nettype none

package ptdc_pkg;

   // number of usable output pins; pin numbers at or above this are rejected
   localparam int PIN_COUNT = 3;
   // width of the pin level vector
   localparam int PIN_W = 3;
   // pin driving the inverted ptt line
   localparam logic [1:0] INVERTED_PIN = 2'd2;
   // pin levels after reset: inverted line high
   localparam logic [PIN_W-1:0] PIN_RESET_LEVELS = 3'b100;
   // longest delay that can be programmed, in 1/1024 s ticks
   localparam logic [15:0] DELAY_MAX = 16'hFFFF;

   // operation codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_ARM  = 2'd2;
   localparam logic [1:0] OP_EDGE = 2'd3;

   // set action codes
   localparam logic [1:0] ACT_ON     = 2'd0;
   localparam logic [1:0] ACT_OFF    = 2'd1;
   localparam logic [1:0] ACT_TOGGLE = 2'd2;

   // reported ptt state codes
   localparam logic [1:0] PTT_IDLE     = 2'd0;
   localparam logic [1:0] PTT_DELAY    = 2'd1;
   localparam logic [1:0] PTT_SIG_WAIT = 2'd2;

   // controller mode, one-hot
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'b001,
      MODE_DELAY    = 3'b010,
      MODE_SIG_WAIT = 3'b100
   } mode_type;

   // request transaction
   typedef struct packed {
      logic [1:0]  operation;
      logic [1:0]  pin_number;
      logic [1:0]  action;
      logic [19:0] delay_ticks;
      logic        wait_signal;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [PIN_W-1:0] pin_levels;
      logic             tone_on;
      logic [1:0]       ctrl_state;
      logic [15:0]      granted_delay;
      logic             rejected;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/push_to_talk_delay_controller.sv =====
// Push-to-talk delay controller top level: request register, core, response register.
// The request is held in the request register, then the state update is written
// into the response register.
// Throughput: one transaction per cycle while rsp_stall is low.
// Reset: synchronous; pins go to 100b, tone off, idle, delay and count cleared.
`default_nettype none

module push_to_talk_delay_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire ptdc_pkg::req_type  req_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output ptdc_pkg::rsp_type       rsp_item
);

   logic              hold_valid_ff, hold_valid_in;
   ptdc_pkg::req_type hold_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   ptdc_pkg::rsp_type rsp_item_ff;
   ptdc_pkg::rsp_type core_rsp;
   logic              advance;
   logic              req_take;

   // handshake control
   assign advance       = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall     = hold_valid_ff && !advance;
   assign req_take      = req_valid && !req_stall;
   assign hold_valid_in = req_take || (hold_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_item_ff <= req_item;
      end
   end

   ptdc_core u_core (
      .clock (clock),
      .reset (reset),
      .en    (advance),
      .item  (hold_item_ff),
      .rsp   (core_rsp)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ptdc_core.sv =====
// controller state and its update for one request
`default_nettype none

module ptdc_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire ptdc_pkg::req_type  item,
   output ptdc_pkg::rsp_type       rsp
);

   logic [ptdc_pkg::PIN_W-1:0] pin_out_ff, pin_out_in;
   logic                       tone_ff, tone_in;
   ptdc_pkg::mode_type         mode_ff, mode_in;
   logic [15:0]                delay_ff, delay_in;
   logic [15:0]                remaining_ff, remaining_in;
   logic [1:0]                 pending_ff, pending_in;

   logic                       pin_ok;
   logic                       set_en;
   logic [1:0]                 set_pin;
   logic [1:0]                 set_act;
   logic [15:0]                sat_delay;
   logic [15:0]                rem_dec;
   logic                       rej;
   logic [ptdc_pkg::PIN_W-1:0] sel_bit;
   logic [ptdc_pkg::PIN_W-1:0] inv_bit;
   logic [ptdc_pkg::PIN_W-1:0] toggled;

   // operand decode
   assign pin_ok    = int'(item.pin_number) < ptdc_pkg::PIN_COUNT;
   assign sat_delay = (|item.delay_ticks[19:16]) ? ptdc_pkg::DELAY_MAX
                                                 : item.delay_ticks[15:0];
   assign rem_dec   = (remaining_ff != 16'd0) ? remaining_ff - 16'd1 : 16'd0;
   assign inv_bit   = ptdc_pkg::PIN_W'(3'b001) << ptdc_pkg::INVERTED_PIN;

   // next state
   always_comb begin
      pin_out_in   = pin_out_ff;
      tone_in      = tone_ff;
      mode_in      = mode_ff;
      delay_in     = delay_ff;
      remaining_in = remaining_ff;
      pending_in   = pending_ff;
      set_en       = 1'b0;
      set_pin      = item.pin_number;
      set_act      = item.action;
      rej          = 1'b0;

      case (item.operation)
         ptdc_pkg::OP_TICK: begin
            if (mode_ff == ptdc_pkg::MODE_DELAY) begin
               remaining_in = rem_dec;
               if (rem_dec == 16'd0) begin
                  set_en  = 1'b1;
                  set_pin = pending_ff;
                  set_act = ptdc_pkg::ACT_ON;
               end
            end
         end
         ptdc_pkg::OP_SET: begin
            if (!pin_ok) begin
               rej = 1'b1;
            end else begin
               set_en = 1'b1;
            end
         end
         ptdc_pkg::OP_ARM: begin
            if (!pin_ok) begin
               rej = 1'b1;
            end else begin
               pending_in = item.pin_number;
               if (!item.wait_signal) begin
                  // counting starts at once, so at least one tick
                  delay_in     = (sat_delay == 16'd0) ? 16'd1 : sat_delay;
                  remaining_in = (sat_delay == 16'd0) ? 16'd1 : sat_delay;
                  mode_in      = ptdc_pkg::MODE_DELAY;
               end else begin
                  delay_in = sat_delay;
                  mode_in  = ptdc_pkg::MODE_SIG_WAIT;
               end
            end
         end
         ptdc_pkg::OP_EDGE: begin
            if (mode_ff == ptdc_pkg::MODE_SIG_WAIT) begin
               if (delay_ff == 16'd0) begin
                  set_en  = 1'b1;
                  set_pin = pending_ff;
                  set_act = ptdc_pkg::ACT_ON;
               end else begin
                  mode_in      = ptdc_pkg::MODE_DELAY;
                  remaining_in = delay_ff;
               end
            end
         end
         default: begin
         end
      endcase

      // selected pin and its toggled levels
      sel_bit = ptdc_pkg::PIN_W'(3'b001) << set_pin;
      toggled = pin_out_ff ^ sel_bit;

      // pin set: cancels any pending delay
      if (set_en) begin
         mode_in      = ptdc_pkg::MODE_IDLE;
         remaining_in = 16'd0;
         case (set_act)
            ptdc_pkg::ACT_ON: begin
               pin_out_in = (pin_out_ff | sel_bit) & ~inv_bit;
               tone_in    = 1'b1;
            end
            ptdc_pkg::ACT_OFF: begin
               pin_out_in = (pin_out_ff & ~sel_bit) | inv_bit;
               tone_in    = 1'b0;
            end
            ptdc_pkg::ACT_TOGGLE: begin
               pin_out_in = toggled;
               tone_in    = |(toggled & sel_bit);
            end
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_out_ff   <= ptdc_pkg::PIN_RESET_LEVELS;
         tone_ff      <= 1'b0;
         mode_ff      <= ptdc_pkg::MODE_IDLE;
         delay_ff     <= 16'd0;
         remaining_ff <= 16'd0;
         pending_ff   <= 2'd0;
      end else if (en) begin
         pin_out_ff   <= pin_out_in;
         tone_ff      <= tone_in;
         mode_ff      <= mode_in;
         delay_ff     <= delay_in;
         remaining_ff <= remaining_in;
         pending_ff   <= pending_in;
      end
   end

   // response from the updated state
   always_comb begin
      rsp.pin_levels    = pin_out_in;
      rsp.tone_on       = tone_in;
      rsp.granted_delay = delay_in;
      rsp.rejected      = rej;
      case (mode_in)
         ptdc_pkg::MODE_DELAY:    rsp.ctrl_state = ptdc_pkg::PTT_DELAY;
         ptdc_pkg::MODE_SIG_WAIT: rsp.ctrl_state = ptdc_pkg::PTT_SIG_WAIT;
         default:                 rsp.ctrl_state = ptdc_pkg::PTT_IDLE;
      endcase
   end

   // counting never sits on a zero count
   a_delay_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ptdc_pkg::MODE_DELAY |-> remaining_ff != 16'd0)
      else $error("delay mode with zero remaining count");

   // only set and arm can be rejected
   a_reject_ops: assert property (@(posedge clock) disable iff (reset)
      en && rsp.rejected |->
         item.operation == ptdc_pkg::OP_SET || item.operation == ptdc_pkg::OP_ARM)
      else $error("rejection on tick or edge");

   // a tick outside delay mode leaves the pins alone
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      en && item.operation == ptdc_pkg::OP_TICK && mode_ff != ptdc_pkg::MODE_DELAY
      |=> $stable(pin_out_ff))
      else $error("pins changed on an idle tick");

   // signal wait is entered only by an arm
   a_sig_wait_entry: assert property (@(posedge clock) disable iff (reset)
      en && item.operation != ptdc_pkg::OP_ARM && mode_ff != ptdc_pkg::MODE_SIG_WAIT
      |=> mode_ff != ptdc_pkg::MODE_SIG_WAIT)
      else $error("signal wait entered without an arm");

endmodule

`default_nettype wire
